/* rtl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH       = 16;
  localparam int ITEM_WIDTH  = 32;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Per-cycle shift command broadcast to every cell; already qualified by full/empty.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

/* rtl/deq_cell.sv */
module deq_cell
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic [ITEM_WIDTH-1:0] item_in,
  input  logic [ITEM_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [ITEM_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [ITEM_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  is_last
);

  logic [ITEM_WIDTH-1:0] data_next;
  logic                  valid_next;

  // Last occupied cell of the row: the back of the queue.
  assign is_last = valid && !right_valid;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (ctrl.push_front) begin
      // Shift toward the back, taking the left neighbor's item.
      data_next  = left_data;
      valid_next = left_valid;
    end else if (ctrl.push_back) begin
      // First empty cell takes the new item.
      if (!valid && left_valid) begin
        data_next  = item_in;
        valid_next = 1'b1;
      end
    end else if (ctrl.pop_front) begin
      // Shift toward the front.
      data_next  = right_data;
      valid_next = right_valid;
    end else if (ctrl.pop_back) begin
      if (is_last) begin
        valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    data <= data_next;
  end

endmodule

/* rtl/double_ended_queue.sv */
// Double-ended queue of DEPTH item words built as a row of cells: cell 0 always
// holds the front item, occupied cells are contiguous from cell 0, and every
// operation shifts the whole row by at most one place. Issue a request by
// raising start with func and item_in; busy never rises, so a new request may
// follow in every cycle. Each request gives exactly one result in the next
// cycle, shown on status, item_out and count_out for exactly one cycle while
// done is high. There is no backpressure on the result side: capture it in
// that cycle or lose it. A push on a full queue reports full and a pop on an
// empty queue reports empty; both leave the queue unchanged. item_out is zero
// for every result other than a successful pop, and count_out always gives the
// number of items held after the request.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func,
  input  logic [ITEM_WIDTH-1:0]  item_in,
  output logic                   done,
  output logic [1:0]             status,
  output logic [ITEM_WIDTH-1:0]  item_out,
  output logic [COUNT_WIDTH-1:0] count_out
);

  func_t                  op;
  logic                   is_push;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;
  status_t                status_next;
  logic [ITEM_WIDTH-1:0]  item_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [ITEM_WIDTH-1:0]  back_item;

  logic [ITEM_WIDTH-1:0]  cell_data  [DEPTH];
  logic                   cell_valid [DEPTH];
  logic                   cell_last  [DEPTH];

  assign busy    = 1'b0;
  assign op      = func_t'(func);
  assign is_push = op inside {FUNC_PUSH_FRONT, FUNC_PUSH_BACK};
  assign full    = (count == COUNT_WIDTH'(DEPTH));
  assign empty   = (count == '0);

  // Qualify the shift command: drop pushes when full and pops when empty.
  always_comb begin
    ctrl.push_front = start && (op == FUNC_PUSH_FRONT) && !full;
    ctrl.push_back  = start && (op == FUNC_PUSH_BACK)  && !full;
    ctrl.pop_front  = start && (op == FUNC_POP_FRONT)  && !empty;
    ctrl.pop_back   = start && (op == FUNC_POP_BACK)   && !empty;
  end

  // Row of cells; cell 0 sees the new item on its left, the last cell sees an
  // empty neighbor on its right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] l_data;
    logic                  l_valid;
    logic [ITEM_WIDTH-1:0] r_data;
    logic                  r_valid;

    if (i == 0) begin : g_first
      assign l_data  = item_in;
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .item_in     (item_in),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .is_last     (cell_last[i])
    );
  end

  // Back item: exactly one cell flags itself as last when the queue is not empty.
  always_comb begin
    back_item = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_item = back_item | (cell_last[i] ? cell_data[i] : '0);
    end
  end

  // Result and count for this request.
  always_comb begin
    status_next = STATUS_DONE;
    item_next   = '0;
    count_next  = count;
    if (is_push) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        count_next = count - 1'b1;
        item_next  = (op == FUNC_POP_FRONT) ? cell_data[0] : back_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
    if (start) begin
      status    <= status_next;
      item_out  <= item_next;
      count_out <= count_next;
    end
  end

endmodule
